FILE: sv/lcdns_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the character LCD nibble sequencer.
// No dependencies; the controller, datapath, top level and testbench import this package.
package lcdns_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CURSOR = 2'd3
  } action_t;

  localparam logic [CfgIndexWidth-1:0] REG_FUNCTION_SET = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_OFF  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_CLEAR        = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ENTRY_MODE   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_ON   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_ADDRESS_BITS = 3'd5;

  localparam logic [7:0] RST_FUNCTION_SET = 8'd40;
  localparam logic [7:0] RST_DISPLAY_OFF  = 8'd8;
  localparam logic [7:0] RST_CLEAR        = 8'd1;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'd6;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'd12;
  localparam logic [7:0] RST_ADDRESS_BITS = 8'd128;

  localparam logic [7:0] WAKE_BYTE_FIRST  = 8'h30;
  localparam logic [7:0] WAKE_BYTE_SECOND = 8'h32;

  localparam logic [15:0] WAIT_POWER_UP = 16'd40000;
  localparam logic [15:0] WAIT_WRITE    = 16'd40;
  localparam logic [15:0] WAIT_CURSOR   = 16'd4040;
  localparam logic [15:0] WAIT_WAKE     = 16'd79;
  localparam logic [15:0] WAIT_SETUP    = 16'd77;
  localparam logic [15:0] WAIT_CLEAR    = 16'd2040;
  localparam logic [15:0] WAIT_MODE     = 16'd80;

  // Phases of one byte: high nibble in 0..2, low nibble in 3..5.
  localparam logic [2:0] PHASE_FIRST      = 3'd0;
  localparam logic [2:0] PHASE_HI_STROBE  = 3'd1;
  localparam logic [2:0] PHASE_LO_START   = 3'd3;
  localparam logic [2:0] PHASE_LO_STROBE  = 3'd4;
  localparam logic [2:0] PHASE_LAST       = 3'd5;

  // Init byte slots.
  localparam logic [2:0] INIT_WAKE_FIRST  = 3'd0;
  localparam logic [2:0] INIT_WAKE_SECOND = 3'd1;
  localparam logic [2:0] INIT_FUNCTION    = 3'd2;
  localparam logic [2:0] INIT_DISPLAY_OFF = 3'd3;
  localparam logic [2:0] INIT_CLEAR       = 3'd4;
  localparam logic [2:0] INIT_ENTRY_MODE  = 3'd5;
  localparam logic [2:0] INIT_DISPLAY_ON  = 3'd6;

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      2'd3:    base = 7'h54;
      default: base = 7'h00;
    endcase
    return base;
  endfunction

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       hold;
    logic       last;
    logic [2:0] phase;
    logic [2:0] byte_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic init_mode;
  } ctrl_status_t;

endpackage

FILE: sv/lcdns_if.sv
`timescale 1ns / 1ps
// Input and result channel interfaces of the character LCD nibble sequencer.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface lcdns_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [1:0] row;
  logic [5:0] column;

  modport source(output valid, output action, output data_byte, output row,
                 output column, input ready);
  modport sink(input valid, input action, input data_byte, input row,
               input column, output ready);
endinterface

interface lcdns_out_if;
  logic        valid;
  logic        ready;
  logic        register_select;
  logic        enable;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  modport source(output valid, output register_select, output enable,
                 output nibble, output wait_us, output last, input ready);
  modport sink(input valid, input register_select, input enable,
               input nibble, input wait_us, input last, output ready);
endinterface

FILE: sv/lcdns_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: steps through the hold state, byte slots and phases.
// Depends on lcdns_pkg; drives the datapath through ctrl_cmd_t.
module lcdns_ctrl
  import lcdns_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   in_action,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HOLD = 3'b010,
    S_BYTE = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [2:0] phase, phase_next;
  logic [2:0] byte_idx, byte_idx_next;
  logic       byte_done;
  logic       item_done;

  assign byte_done = (phase == PHASE_LAST);
  assign item_done = byte_done && (!status.init_mode || byte_idx == INIT_DISPLAY_ON);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    byte_idx_next = byte_idx;
    cmd.load      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.hold      = 1'b0;
    cmd.last      = 1'b0;
    cmd.phase     = phase;
    cmd.byte_idx  = byte_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          phase_next    = PHASE_FIRST;
          byte_idx_next = INIT_WAKE_FIRST;
          state_next    = (action_t'(in_action) == ACT_INIT) ? S_HOLD : S_BYTE;
        end
      end
      S_HOLD: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.hold   = 1'b1;
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = item_done;
          if (item_done) begin
            state_next = S_IDLE;
          end else if (byte_done) begin
            phase_next    = PHASE_FIRST;
            byte_idx_next = byte_idx + 3'd1;
          end else begin
            phase_next = phase + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PHASE_FIRST;
      byte_idx <= INIT_WAKE_FIRST;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      byte_idx <= byte_idx_next;
    end
  end

endmodule

FILE: sv/lcdns_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, item latch, byte and wait selection,
// and the result register. Depends on lcdns_pkg and the lcdns_out_if interface.
module lcdns_dp
  import lcdns_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic [1:0]               in_action,
  input  logic [7:0]               in_data_byte,
  input  logic [1:0]               in_row,
  input  logic [5:0]               in_column,
  input  ctrl_cmd_t                cmd,
  output ctrl_status_t             status,
  lcdns_out_if.source              out_ch
);

  logic [7:0] function_set_command;
  logic [7:0] display_off_command;
  logic [7:0] clear_command;
  logic [7:0] entry_mode_command;
  logic [7:0] display_on_command;
  logic [7:0] address_command_bits;

  action_t    act;
  logic [7:0] byte_q;
  logic [6:0] cursor_addr;
  logic [7:0] cursor_cmd;
  logic [7:0] cur_byte;
  logic [15:0] byte_wait;
  logic       out_valid;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_set_command <= RST_FUNCTION_SET;
      display_off_command  <= RST_DISPLAY_OFF;
      clear_command        <= RST_CLEAR;
      entry_mode_command   <= RST_ENTRY_MODE;
      display_on_command   <= RST_DISPLAY_ON;
      address_command_bits <= RST_ADDRESS_BITS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FUNCTION_SET: function_set_command <= cfg_data;
        REG_DISPLAY_OFF:  display_off_command  <= cfg_data;
        REG_CLEAR:        clear_command        <= cfg_data;
        REG_ENTRY_MODE:   entry_mode_command   <= cfg_data;
        REG_DISPLAY_ON:   display_on_command   <= cfg_data;
        REG_ADDRESS_BITS: address_command_bits <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cursor_addr = row_base(in_row) + {1'b0, in_column};
  assign cursor_cmd  = {1'b0, cursor_addr} | address_command_bits;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action_t'(in_action);
      byte_q <= (action_t'(in_action) == ACT_CURSOR) ? cursor_cmd : in_data_byte;
    end
  end

  always_comb begin
    cur_byte  = byte_q;
    byte_wait = WAIT_WRITE;
    case (act)
      ACT_INIT: begin
        case (cmd.byte_idx)
          INIT_WAKE_FIRST:  begin cur_byte = WAKE_BYTE_FIRST;      byte_wait = WAIT_WAKE;  end
          INIT_WAKE_SECOND: begin cur_byte = WAKE_BYTE_SECOND;     byte_wait = WAIT_WAKE;  end
          INIT_FUNCTION:    begin cur_byte = function_set_command; byte_wait = WAIT_SETUP; end
          INIT_DISPLAY_OFF: begin cur_byte = display_off_command;  byte_wait = WAIT_SETUP; end
          INIT_CLEAR:       begin cur_byte = clear_command;        byte_wait = WAIT_CLEAR; end
          INIT_ENTRY_MODE:  begin cur_byte = entry_mode_command;   byte_wait = WAIT_MODE;  end
          default:          begin cur_byte = display_on_command;   byte_wait = WAIT_MODE;  end
        endcase
      end
      ACT_CURSOR: byte_wait = WAIT_CURSOR;
      default: byte_wait = WAIT_WRITE;
    endcase
  end

  assign out_free         = !out_valid || out_ch.ready;
  assign status.out_free  = out_free;
  assign status.init_mode = (act == ACT_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.hold) begin
        out_ch.register_select <= 1'b0;
        out_ch.enable          <= 1'b0;
        out_ch.nibble          <= 4'd0;
        out_ch.wait_us         <= WAIT_POWER_UP;
        out_ch.last            <= 1'b0;
      end else begin
        out_ch.register_select <= (act == ACT_DATA);
        out_ch.enable          <= (cmd.phase == PHASE_HI_STROBE) ||
                                  (cmd.phase == PHASE_LO_STROBE);
        out_ch.nibble          <= (cmd.phase < PHASE_LO_START) ? cur_byte[7:4]
                                                               : cur_byte[3:0];
        out_ch.wait_us         <= (cmd.phase == PHASE_LAST) ? byte_wait : 16'd0;
        out_ch.last            <= cmd.last;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

FILE: sv/char_lcd_nibble_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the character LCD nibble sequencer for a 4-bit HD44780-style bus.
// Depends on lcdns_pkg, lcdns_if, lcdns_ctrl and lcdns_dp.
//
// One input transaction carries an action: initialize, write a command byte,
// write a data byte, or set the cursor from a row and a column. Each result
// transaction is one pin state for RS, E and D7..D4 together with the time in
// microseconds to hold it; last marks the final pin state of the action.
// A byte gives six pin states, high nibble first, each nibble as data with E
// low, E high, E low. Initialization gives a power-up hold state and seven
// bytes, 43 pin states in all.
// After the input transaction is accepted, the controller loads one pin state
// per cycle into the result register while the receiver takes them, set by the
// phase and byte counters of the controller. The next input is taken in the
// cycle after the last pin state is loaded into the result register, while
// that result still waits. When the receiver stalls, the result register holds
// and the sequence pauses. Reset is synchronous: it returns the controller to
// idle, empties the result register and loads the standard init command bytes
// into the registers. Registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while idle, as the block itself
// does not enforce it.
module char_lcd_nibble_sequencer_unit
  import lcdns_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  lcdns_in_if.sink                 in_ch,
  lcdns_out_if.source              out_ch
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  lcdns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdns_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_action    (in_ch.action),
    .in_data_byte (in_ch.data_byte),
    .in_row       (in_ch.row),
    .in_column    (in_ch.column),
    .cmd          (cmd),
    .status       (status),
    .out_ch       (out_ch)
  );

endmodule

FILE: tb/tb_char_lcd_nibble_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_sequencer_unit.
// Depends on lcdns_pkg, lcdns_if and the RTL of the block; drives actions and
// compares every pin state against an in-bench prediction.
module tb_char_lcd_nibble_sequencer_unit;
  import lcdns_pkg::*;

  localparam int StallLimit  = 3000;
  localparam int LongHold    = 300;
  localparam int PhaseItems  = 40;
  localparam int RegSlots    = 1 << CfgIndexWidth;
  localparam int ShownErrors = 40;

  typedef struct {
    action_t    action;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [5:0] column;
  } lcd_action_t;

  typedef struct {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold_us;
    logic        last_state;
  } pin_state_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  lcdns_in_if in_ch();
  lcdns_out_if out_ch();

  char_lcd_nibble_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  lcd_action_t action_queue[$];
  pin_state_t pin_state_queue[$];
  logic [7:0] cmd_shadow[0:5];
  logic [7:0] next_regs[0:RegSlots-1];

  bit in_took;
  bit out_took;
  bit send_burst;
  bit recv_burst;
  bit hold_arm;
  int send_gap;
  int recv_gap;
  int hold_left;
  int idle_cycles;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic emit_byte(input logic rs, input logic [7:0] b, input logic [15:0] w,
                           input logic lst);
    pin_state_queue.push_back('{rs, 1'b0, b[7:4], 16'd0, 1'b0});
    pin_state_queue.push_back('{rs, 1'b1, b[7:4], 16'd0, 1'b0});
    pin_state_queue.push_back('{rs, 1'b0, b[7:4], 16'd0, 1'b0});
    pin_state_queue.push_back('{rs, 1'b0, b[3:0], 16'd0, 1'b0});
    pin_state_queue.push_back('{rs, 1'b1, b[3:0], 16'd0, 1'b0});
    pin_state_queue.push_back('{rs, 1'b0, b[3:0], w, lst});
  endtask

  task automatic predict_pins(input lcd_action_t it);
    logic [6:0] origin;
    logic [6:0] addr;
    case (it.action)
      ACT_INIT: begin
        pin_state_queue.push_back('{1'b0, 1'b0, 4'd0, WAIT_POWER_UP, 1'b0});
        emit_byte(1'b0, WAKE_BYTE_FIRST, WAIT_WAKE, 1'b0);
        emit_byte(1'b0, WAKE_BYTE_SECOND, WAIT_WAKE, 1'b0);
        emit_byte(1'b0, cmd_shadow[REG_FUNCTION_SET], WAIT_SETUP, 1'b0);
        emit_byte(1'b0, cmd_shadow[REG_DISPLAY_OFF], WAIT_SETUP, 1'b0);
        emit_byte(1'b0, cmd_shadow[REG_CLEAR], WAIT_CLEAR, 1'b0);
        emit_byte(1'b0, cmd_shadow[REG_ENTRY_MODE], WAIT_MODE, 1'b0);
        emit_byte(1'b0, cmd_shadow[REG_DISPLAY_ON], WAIT_MODE, 1'b1);
      end
      ACT_CMD: emit_byte(1'b0, it.data_byte, WAIT_WRITE, 1'b1);
      ACT_DATA: emit_byte(1'b1, it.data_byte, WAIT_WRITE, 1'b1);
      default: begin
        case (it.row)
          2'd0: origin = 7'h00;
          2'd1: origin = 7'h40;
          2'd2: origin = 7'h14;
          default: origin = 7'h54;
        endcase
        addr = origin + {1'b0, it.column};
        emit_byte(1'b0, {1'b0, addr} | cmd_shadow[REG_ADDRESS_BITS], WAIT_CURSOR, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ShownErrors) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    end
  endtask

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic lcd_action_t random_action();
    lcd_action_t it;
    int pick;
    pick = $urandom_range(0, 9);
    it.action = (pick == 0) ? ACT_INIT : action_t'(2'(1 + pick % 3));
    it.data_byte = 8'($urandom);
    it.row = 2'($urandom);
    it.column = 6'($urandom);
    return it;
  endfunction

  // Action driver: holds an offered transaction until it is taken.
  always @(negedge clk) begin
    lcd_action_t cur;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (action_queue.size() > 0) begin
        cur = action_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= cur.action;
        in_ch.data_byte <= cur.data_byte;
        in_ch.row <= cur.row;
        in_ch.column <= cur.column;
        send_gap = draw_gap(send_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Pin state receiver with per-transaction gaps and an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (hold_arm) begin
        hold_left = LongHold;
        hold_arm = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_ch.ready && !out_took) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (out_took) recv_gap = draw_gap(recv_burst);
        if (recv_gap > 0) begin
          recv_gap--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Monitor: register shadow, prediction, checking and the watchdog.
  always @(posedge clk) begin
    pin_state_t want;
    lcd_action_t seen;
    in_took <= in_ch.valid && in_ch.ready;
    out_took <= out_ch.valid && out_ch.ready;
    if (rst) begin
      cmd_shadow[REG_FUNCTION_SET] = RST_FUNCTION_SET;
      cmd_shadow[REG_DISPLAY_OFF] = RST_DISPLAY_OFF;
      cmd_shadow[REG_CLEAR] = RST_CLEAR;
      cmd_shadow[REG_ENTRY_MODE] = RST_ENTRY_MODE;
      cmd_shadow[REG_DISPLAY_ON] = RST_DISPLAY_ON;
      cmd_shadow[REG_ADDRESS_BITS] = RST_ADDRESS_BITS;
      idle_cycles = 0;
    end else begin
      if (cfg_write && cfg_index <= REG_ADDRESS_BITS) cmd_shadow[cfg_index] = cfg_data;
      if (out_ch.valid && out_ch.ready) begin
        if (pin_state_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("%0t: unexpected pin state, expected none, actual rs=%0d e=%0d d=%h w=%0d l=%0d",
                     $time, out_ch.register_select, out_ch.enable, out_ch.nibble,
                     out_ch.wait_us, out_ch.last);
          end
        end else begin
          want = pin_state_queue.pop_front();
          check_field("register_select", want.rs, out_ch.register_select);
          check_field("enable", want.en, out_ch.enable);
          check_field("nibble", want.nib, out_ch.nibble);
          check_field("wait_us", want.hold_us, out_ch.wait_us);
          check_field("last", want.last_state, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.action = action_t'(in_ch.action);
        seen.data_byte = in_ch.data_byte;
        seen.row = in_ch.row;
        seen.column = in_ch.column;
        predict_pins(seen);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("tb_char_lcd_nibble_sequencer_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    do begin
      @(posedge clk);
    end while (action_queue.size() != 0 || in_ch.valid || pin_state_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < RegSlots; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= i[CfgIndexWidth-1:0];
      cfg_data <= next_regs[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_action(input action_t a, input logic [7:0] b, input logic [1:0] r,
                             input logic [5:0] c);
    action_queue.push_back('{a, b, r, c});
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INIT;
    in_ch.data_byte = '0;
    in_ch.row = '0;
    in_ch.column = '0;
    out_ch.ready = 1'b0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    hold_arm = 1'b0;
    mismatches = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed actions at the reset register values.
    push_action(ACT_INIT, 8'h00, 2'd0, 6'd0);
    push_action(ACT_CMD, 8'h00, 2'd3, 6'd63);
    push_action(ACT_CMD, 8'hFF, 2'd0, 6'd0);
    push_action(ACT_DATA, 8'h00, 2'd3, 6'd63);
    push_action(ACT_DATA, 8'hFF, 2'd1, 6'd21);
    push_action(ACT_DATA, 8'hA5, 2'd2, 6'd42);
    push_action(ACT_CMD, 8'h5A, 2'd1, 6'd1);
    push_action(ACT_CURSOR, 8'hFF, 2'd0, 6'd0);
    push_action(ACT_CURSOR, 8'h00, 2'd1, 6'd0);
    push_action(ACT_CURSOR, 8'hA5, 2'd2, 6'd0);
    push_action(ACT_CURSOR, 8'h5A, 2'd3, 6'd0);
    push_action(ACT_CURSOR, 8'h00, 2'd0, 6'd63);
    push_action(ACT_CURSOR, 8'h00, 2'd1, 6'd63);
    push_action(ACT_CURSOR, 8'h00, 2'd2, 6'd63);
    push_action(ACT_CURSOR, 8'h00, 2'd3, 6'd63);
    push_action(ACT_INIT, 8'hFF, 2'd3, 6'd63);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        for (int i = 0; i < RegSlots; i++) begin
          case (phase)
            1: next_regs[i] = 8'hFF;
            2: next_regs[i] = 8'h00;
            default: next_regs[i] = 8'($urandom);
          endcase
        end
        program_regs();
      end
      send_burst = (phase == 1) || (phase == 3);
      recv_burst = (phase == 3);
      if (phase == 1) hold_arm = 1'b1;
      for (int n = 0; n < PhaseItems; n++) action_queue.push_back(random_action());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pin_state_queue.size() == 0) begin
      $display("tb_char_lcd_nibble_sequencer_unit: PASS");
    end else begin
      $display("tb_char_lcd_nibble_sequencer_unit: FAIL");
    end
    $finish;
  end

endmodule
